@@ rtl/core/signed_int_to_decimal_text_assert.svh @@
// Assertion macros shared by the decimal text RTL.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH

// Same-cycle implication, reset disables the check.
`define SITD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disables the check.
`define SITD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sitd_pkg.sv @@
// Package for the signed integer to decimal text block.
// Types, constants and helpers; no dependencies.
`timescale 1ns / 1ps

package sitd_pkg;

    localparam int FIELD_WIDTH_DEF = 5;
    localparam int VALUE_BITS      = 18;
    localparam int MAG_BITS        = 18;
    localparam int BCD_DIGITS      = 6;
    localparam int BCD_BITS        = 4 * BCD_DIGITS;
    localparam int STEP_BITS       = 3;
    localparam int BCD_STAGES      = MAG_BITS / STEP_BITS;
    localparam int ND_W            = $clog2(BCD_DIGITS + 1);
    localparam int CHAR_W          = 7;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

    // Word between the converter pipeline and the text stages.
    typedef struct packed {
        logic                neg;
        logic [BCD_BITS-1:0] bcd;
    } bcd_word_t;

    // Double-dabble working word.
    typedef struct packed {
        logic                neg;
        logic [BCD_BITS-1:0] bcd;
        logic [MAG_BITS-1:0] bin;
    } dd_word_t;

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int k = 0; k < n; k++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // One shift-add-3 step: adjust digits, then shift in the next binary bit.
    function automatic dd_word_t dd_step(input dd_word_t w);
        dd_word_t r;
        r = w;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (r.bcd[4*d +: 4] >= 4'd5) begin
                r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
            end
        end
        r.bcd = {r.bcd[BCD_BITS-2:0], r.bin[MAG_BITS-1]};
        r.bin = {r.bin[MAG_BITS-2:0], 1'b0};
        return r;
    endfunction

endpackage

@@ rtl/core/signed_int_to_decimal_text.sv @@
// The first character strobes once a taken start has passed the stages listed below, then one per cycle.
// Values stream in until a built field waits in the text stage for the serializer;
//   busy then holds the input until the serializer takes that field.
// Pipeline: clamp, six conversion stages, lead-digit, text build, serializer.
// Reset clears all valid bits and the serializer; no word is emitted after reset.
// The receiver cannot stall: each word is on the ports for exactly one cycle.
`timescale 1ns / 1ps

module signed_int_to_decimal_text
    import sitd_pkg::*;
#(
    parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         char_strobe,
    output logic        [CHAR_W-1:0]     text_char,
    output logic                         last_char
);

    // Saturation limits, narrowed to what an 18-bit input can reach.
    localparam longint HI_L  = pow10(FIELD_WIDTH) - 1;
    localparam longint LO_L  = -(pow10(FIELD_WIDTH - 1) - 1);
    localparam longint VMAX  = (longint'(1) << (VALUE_BITS - 1)) - 1;
    localparam longint VMIN  = -(longint'(1) << (VALUE_BITS - 1));
    localparam longint HI_C  = (HI_L > VMAX) ? VMAX : HI_L;
    localparam longint LO_C  = (LO_L < VMIN) ? VMIN : LO_L;
    localparam logic signed [VALUE_BITS:0] HI_SAT = (VALUE_BITS + 1)'(HI_C);
    localparam logic signed [VALUE_BITS:0] LO_SAT = (VALUE_BITS + 1)'(LO_C);
    localparam int IDX_W = $clog2(FIELD_WIDTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FIELD_WIDTH - 1);

    // ------------------------------------------------------------------
    // Global advance: every stage up to the text stage moves unless the text stage holds a field
    // that the serializer cannot take yet.
    // ------------------------------------------------------------------
    logic adv;
    logic ser_take;

    // Stage 1: clamp and magnitude
    logic                        clamp_valid_reg;
    logic                        clamp_neg_reg;
    logic                        clamp_neg_next;
    logic [MAG_BITS-1:0]         clamp_mag_reg;
    logic [MAG_BITS-1:0]         clamp_mag_next;
    logic signed [VALUE_BITS:0]  vx;
    logic signed [VALUE_BITS:0]  vc;
    logic signed [VALUE_BITS:0]  vmag;

    always_comb
    begin
        vx = {value[VALUE_BITS-1], value};
        if (vx > HI_SAT) begin
            vc = HI_SAT;
        end else if (vx < LO_SAT) begin
            vc = LO_SAT;
        end else begin
            vc = vx;
        end
        clamp_neg_next = vc[VALUE_BITS];
        vmag           = clamp_neg_next ? -vc : vc;
        clamp_mag_next = vmag[MAG_BITS-1:0];
    end

    // Stages 2..7: binary to BCD
    logic      pipe_valid;
    bcd_word_t pipe_word;

    sitd_bcd_pipe u_bcd_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (clamp_valid_reg),
        .in_neg    (clamp_neg_reg),
        .in_mag    (clamp_mag_reg),
        .out_valid (pipe_valid),
        .out_word  (pipe_word)
    );

    // Stage 8: count significant digits (zero still prints one)
    logic            lead_valid_reg;
    bcd_word_t       lead_word_reg;
    logic [ND_W-1:0] lead_nd_reg;
    logic [ND_W-1:0] lead_nd_next;

    always_comb
    begin
        lead_nd_next = ND_W'(1);
        for (int j = 1; j < BCD_DIGITS; j++) begin
            if (pipe_word.bcd[4*j +: 4] != 4'd0) begin
                lead_nd_next = ND_W'(j + 1);
            end
        end
    end

    // Stage 9: build the field, sign then digits then padding
    logic                                 text_valid_reg;
    logic [FIELD_WIDTH-1:0][CHAR_W-1:0]   text_reg;
    logic [FIELD_WIDTH-1:0][CHAR_W-1:0]   text_next;

    always_comb
    begin
        logic [4:0] rel;
        logic [4:0] dsel;
        for (int k = 0; k < FIELD_WIDTH; k++) begin
            rel  = 5'(k) - {4'b0, lead_word_reg.neg};
            dsel = {{(5 - ND_W){1'b0}}, lead_nd_reg} - 5'd1 - rel;
            text_next[k] = CH_SPACE;
            if (lead_word_reg.neg && k == 0) begin
                text_next[k] = CH_MINUS;
            end else if (rel < {{(5 - ND_W){1'b0}}, lead_nd_reg}) begin
                for (int j = 0; j < BCD_DIGITS; j++) begin
                    if (dsel == 5'(j)) begin
                        text_next[k] = CH_ZERO + {3'b0, lead_word_reg.bcd[4*j +: 4]};
                    end
                end
            end
        end
    end

    // Serializer: shifts one character out per cycle
    logic                               ser_valid_reg;
    logic [IDX_W-1:0]                   ser_idx_reg;
    logic [FIELD_WIDTH-1:0][CHAR_W-1:0] ser_text_reg;
    logic [FIELD_WIDTH-1:0][CHAR_W-1:0] ser_text_next;
    logic                               ser_last;

    assign ser_last = (ser_idx_reg == IDX_LAST);
    assign ser_take = !ser_valid_reg || ser_last;
    assign adv      = !(text_valid_reg && !ser_take);
    assign busy     = !adv;

    always_comb
    begin
        for (int k = 0; k < FIELD_WIDTH - 1; k++) begin
            ser_text_next[k] = ser_text_reg[k+1];
        end
        ser_text_next[FIELD_WIDTH-1] = CH_SPACE;
    end

    // Valid bits and serializer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clamp_valid_reg <= 1'b0;
            lead_valid_reg  <= 1'b0;
            text_valid_reg  <= 1'b0;
            ser_valid_reg   <= 1'b0;
            ser_idx_reg     <= '0;
        end else begin
            if (adv) begin
                clamp_valid_reg <= start;
                lead_valid_reg  <= pipe_valid;
                text_valid_reg  <= lead_valid_reg;
            end
            if (ser_take) begin
                ser_valid_reg <= text_valid_reg;
                ser_idx_reg   <= '0;
            end else begin
                ser_idx_reg   <= ser_idx_reg + IDX_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv) begin
            clamp_neg_reg <= clamp_neg_next;
            clamp_mag_reg <= clamp_mag_next;
            lead_word_reg <= pipe_word;
            lead_nd_reg   <= lead_nd_next;
            text_reg      <= text_next;
        end
        if (ser_take) begin
            ser_text_reg <= text_reg;
        end else begin
            ser_text_reg <= ser_text_next;
        end
    end

    assign char_strobe = ser_valid_reg;
    assign text_char   = ser_text_reg[0];
    assign last_char   = ser_valid_reg && ser_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`include "signed_int_to_decimal_text_assert.svh"

    `SITD_ASSERT_NEXT(a_field_no_gap, char_strobe && !last_char, char_strobe, "field broken by a gap")
    `SITD_ASSERT_NOW(a_field_starts_at_zero, $rose(char_strobe), ser_idx_reg == '0, "field does not start at first char")
    `SITD_ASSERT_NOW(a_stall_reaches_input, text_valid_reg && !ser_take, busy, "input open while text stage is stalled")
    `SITD_ASSERT_NOW(a_first_char_printed, text_valid_reg, text_reg[0] != CH_SPACE, "field opens with padding")

endmodule

@@ rtl/core/sitd_bcd_pipe.sv @@
// Pipelined binary to BCD converter, STEP_BITS bits per stage.
// Depends on sitd_pkg.
`timescale 1ns / 1ps

module sitd_bcd_pipe
    import sitd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic                in_neg,
    input  logic [MAG_BITS-1:0] in_mag,
    output logic                out_valid,
    output bcd_word_t           out_word
);

    logic     [BCD_STAGES-1:0] valid_reg;
    dd_word_t                  word_reg  [BCD_STAGES];
    dd_word_t                  word_next [BCD_STAGES];

    // Combinational steps of each stage
    always_comb
    begin
        dd_word_t w;
        for (int s = 0; s < BCD_STAGES; s++) begin
            if (s == 0) begin
                w.neg = in_neg;
                w.bcd = '0;
                w.bin = in_mag;
            end else begin
                w = word_reg[s-1];
            end
            for (int b = 0; b < STEP_BITS; b++) begin
                w = dd_step(w);
            end
            word_next[s] = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[BCD_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            for (int s = 0; s < BCD_STAGES; s++) begin
                word_reg[s] <= word_next[s];
            end
        end
    end

    assign out_valid    = valid_reg[BCD_STAGES-1];
    assign out_word.neg = word_reg[BCD_STAGES-1].neg;
    assign out_word.bcd = word_reg[BCD_STAGES-1].bcd;

endmodule
